### rtl/core/rrts_pkg.sv
// rrts_pkg: shared types and constants of the round-robin task scheduler
// used by the channel interfaces and by the scheduler module

package rrts_pkg;

	// default size of the task slot pool
	localparam int unsigned NUM_SLOTS_DEF = 32;

	// fixed payload widths of the command and result channels
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned TASK_SLOT_W  = 5;
	localparam int unsigned OUT_SLOT_W   = 5;
	localparam int unsigned OUT_CNT_W    = 6;
	localparam int unsigned STATUS_W     = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_ADD   = 2'd2,
		MODE_SLEEP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SLOT_FREE   = 2'd0,
		SLOT_SLEEP  = 2'd1,
		SLOT_ACTIVE = 2'd2
	} slot_st_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK           = 3'd0,
		STAT_NO_FREE      = 3'd1,
		STAT_ADD_REFUSED  = 3'd2,
		STAT_NOT_ACTIVE   = 3'd3,
		STAT_NO_TASK_LEFT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_STAT_RD,
		S_STAT_CHK,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_LIST_RD,
		S_LIST_CHK,
		S_SLEEP_FIN,
		S_CUR_RD,
		S_CUR_WAIT,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [OUT_SLOT_W-1:0] running_slot;
		logic                  switched;
		logic [OUT_SLOT_W-1:0] allocated_slot;
		logic [OUT_CNT_W-1:0]  active_count;
		status_t               status;
	} res_t;

endpackage

### rtl/core/rrts_if.sv
// rrts_if: valid/ready channel interfaces for scheduler commands and results
// depends on rrts_pkg for payload types and widths

interface rrts_cmd_if;
	import rrts_pkg::*;

	logic                   valid;
	logic                   ready;
	mode_t                  mode;
	logic [TASK_SLOT_W-1:0] task_slot;

	modport source (output valid, mode, task_slot, input ready);
	modport sink   (input valid, mode, task_slot, output ready);
endinterface

interface rrts_res_if;
	import rrts_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OUT_SLOT_W-1:0] running_slot;
	logic                  switched;
	logic [OUT_SLOT_W-1:0] allocated_slot;
	logic [OUT_CNT_W-1:0]  active_count;
	status_t               status;

	modport source (output valid, running_slot, switched, allocated_slot, active_count,
		status, input ready);
	modport sink   (input valid, running_slot, switched, allocated_slot, active_count,
		status, output ready);
endinterface

### rtl/core/rrts_ram.sv
// rrts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rrts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/round_robin_task_scheduler.sv
// round_robin_task_scheduler: round-robin scheduler over a pool of task slots
// add and sleep read and check the slot status, allocate checks each slot scanned and
// sleep scans each run list entry, and every command then refreshes the running slot;
// one command is taken at a time, set by the single read port of each ram and one sequencer
// reset: arst_n starts a clearing pass over all NUM_SLOTS slots with no command beat
// taken, then slot 0 is active and running; depends on rrts_pkg, rrts_if and rrts_ram

module round_robin_task_scheduler #(
	parameter int unsigned NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rrts_cmd_if.sink   cmd,
	rrts_res_if.source res
);
	import rrts_pkg::*;

	// slot index, run count and widened views for the fixed-width ports
	localparam int unsigned SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CNT_W   = $clog2(NUM_SLOTS + 1);
	localparam int unsigned IDX_EXT = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;
	localparam int unsigned CNT_EXT = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
	localparam int unsigned TS_EXT  = (SLOT_W > TASK_SLOT_W) ? SLOT_W : TASK_SLOT_W;

	// sequencer and architectural state
	fsm_t              state_q, state_d;
	logic [SLOT_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [SLOT_W-1:0] pos_q, pos_d;
	logic [SLOT_W-1:0] cur_q, cur_d;
	logic              res_valid_q, res_valid_d;

	// per-command working registers
	mode_t             mode_q, mode_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic [SLOT_W-1:0] fidx_q, fidx_d;
	logic              found_q, found_d;
	logic              switched_q, switched_d;
	logic [SLOT_W-1:0] granted_q, granted_d;
	status_t           stat_q, stat_d;
	res_t              res_q, res_d;

	// ram ports
	logic              st_we;
	logic [SLOT_W-1:0] st_waddr, st_raddr;
	slot_st_t          st_wdata;
	logic [1:0]        st_rdata;
	logic              lst_we;
	logic [SLOT_W-1:0] lst_waddr, lst_raddr, lst_wdata, lst_rdata;

	// helper values
	logic [TS_EXT-1:0]  slot_ext;
	logic               slot_ok;
	logic [CNT_W-1:0]   pos_inc;
	logic [CNT_W-1:0]   cnt_dec;
	logic [SLOT_W-1:0]  pos_adj;
	logic [IDX_EXT-1:0] cur_ext, granted_ext;
	logic [CNT_EXT-1:0] cnt_ext;

	// slot status per slot: free, sleeping or active
	rrts_ram #(
		.WIDTH(2),
		.DEPTH(NUM_SLOTS)
	) u_status_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// ordered run list of active slots, entries past the count are dead
	rrts_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(NUM_SLOTS)
	) u_list_ram (
		.clk  (clk),
		.we   (lst_we),
		.waddr(lst_waddr),
		.wdata(lst_wdata),
		.raddr(lst_raddr),
		.rdata(lst_rdata)
	);

	// command slot range check and index
	assign slot_ext = TS_EXT'(cmd.task_slot);
	assign slot_ok  = 32'(cmd.task_slot) < 32'(NUM_SLOTS);

	// tick advance, and run position fix-up after a removal
	assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
	assign cnt_dec = cnt_q - CNT_W'(1);

	always_comb begin
		pos_adj = (fidx_q < pos_q) ? (pos_q - SLOT_W'(1)) : pos_q;
		if (CNT_W'(pos_adj) >= cnt_dec) begin
			pos_adj = '0;
		end
	end

	// result fields are reported in their low bits
	assign cur_ext     = IDX_EXT'(cur_q);
	assign granted_ext = IDX_EXT'(granted_q);
	assign cnt_ext     = CNT_EXT'(cnt_q);

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		cur_d       = cur_q;
		res_valid_d = res_valid_q & ~res.ready;
		mode_d      = mode_q;
		slot_d      = slot_q;
		idx_d       = idx_q;
		fidx_d      = fidx_q;
		found_d     = found_q;
		switched_d  = switched_q;
		granted_d   = granted_q;
		stat_d      = stat_q;
		res_d       = res_q;

		st_we     = 1'b0;
		st_waddr  = slot_q;
		st_wdata  = SLOT_FREE;
		st_raddr  = slot_q;
		lst_we    = 1'b0;
		lst_waddr = idx_q;
		lst_wdata = slot_q;
		lst_raddr = idx_q;

		cmd.ready = (state_q == S_IDLE);

		case (state_q)
			// one slot per cycle: slot 0 active in list entry 0, the rest free
			S_CLEAR: begin
				st_we     = 1'b1;
				st_waddr  = clr_q;
				st_wdata  = (clr_q == '0) ? SLOT_ACTIVE : SLOT_FREE;
				lst_we    = 1'b1;
				lst_waddr = clr_q;
				lst_wdata = '0;
				if (clr_q == SLOT_W'(NUM_SLOTS - 1)) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + SLOT_W'(1);
				end
			end

			S_IDLE: begin
				if (cmd.valid) begin
					mode_d     = cmd.mode;
					slot_d     = slot_ext[SLOT_W-1:0];
					idx_d      = '0;
					found_d    = 1'b0;
					switched_d = 1'b0;
					granted_d  = '0;
					stat_d     = STAT_OK;
					case (cmd.mode)
						MODE_TICK: begin
							// a single task keeps running without a switch
							if (cnt_q >= CNT_W'(2)) begin
								pos_d      = (pos_inc == cnt_q) ? '0 : pos_inc[SLOT_W-1:0];
								switched_d = 1'b1;
							end
							state_d = S_CUR_RD;
						end
						MODE_ALLOC: begin
							state_d = S_ALLOC_RD;
						end
						MODE_ADD, MODE_SLEEP: begin
							if (slot_ok) begin
								state_d = S_STAT_RD;
							end else begin
								stat_d  = (cmd.mode == MODE_ADD) ? STAT_ADD_REFUSED
									: STAT_NOT_ACTIVE;
								state_d = S_CUR_RD;
							end
						end
						default: begin
							state_d = S_CUR_RD;
						end
					endcase
				end
			end

			S_STAT_RD: begin
				st_raddr = slot_q;
				state_d  = S_STAT_CHK;
			end

			S_STAT_CHK: begin
				state_d = S_CUR_RD;
				if (mode_q == MODE_ADD) begin
					// append to the tail of the run list
					if (slot_st_t'(st_rdata) != SLOT_SLEEP || cnt_q >= CNT_W'(NUM_SLOTS)) begin
						stat_d = STAT_ADD_REFUSED;
					end else begin
						st_we     = 1'b1;
						st_waddr  = slot_q;
						st_wdata  = SLOT_ACTIVE;
						lst_we    = 1'b1;
						lst_waddr = cnt_q[SLOT_W-1:0];
						lst_wdata = slot_q;
						cnt_d     = cnt_q + CNT_W'(1);
					end
				end else begin
					if (slot_st_t'(st_rdata) != SLOT_ACTIVE) begin
						stat_d = STAT_NOT_ACTIVE;
					end else if (cnt_q <= CNT_W'(1)) begin
						// last active task stays running
						stat_d = STAT_NO_TASK_LEFT;
					end else begin
						state_d = S_LIST_RD;
					end
				end
			end

			// first-free search from slot 0, a read state and a check state per slot
			S_ALLOC_RD: begin
				st_raddr = idx_q;
				state_d  = S_ALLOC_CHK;
			end

			S_ALLOC_CHK: begin
				if (slot_st_t'(st_rdata) == SLOT_FREE) begin
					st_we     = 1'b1;
					st_waddr  = idx_q;
					st_wdata  = SLOT_SLEEP;
					granted_d = idx_q;
					state_d   = S_CUR_RD;
				end else if (idx_q == SLOT_W'(NUM_SLOTS - 1)) begin
					stat_d  = STAT_NO_FREE;
					state_d = S_CUR_RD;
				end else begin
					idx_d   = idx_q + SLOT_W'(1);
					state_d = S_ALLOC_RD;
				end
			end

			// one pass over the run list: find the slot, then shift the tail down
			S_LIST_RD: begin
				lst_raddr = idx_q;
				state_d   = S_LIST_CHK;
			end

			S_LIST_CHK: begin
				if (!found_q && lst_rdata == slot_q) begin
					found_d = 1'b1;
					fidx_d  = idx_q;
				end else if (found_q) begin
					lst_we    = 1'b1;
					lst_waddr = idx_q - SLOT_W'(1);
					lst_wdata = lst_rdata;
				end
				if (CNT_W'(idx_q) == cnt_dec) begin
					state_d = S_SLEEP_FIN;
				end else begin
					idx_d   = idx_q + SLOT_W'(1);
					state_d = S_LIST_RD;
				end
			end

			S_SLEEP_FIN: begin
				if (!found_q) begin
					stat_d = STAT_NOT_ACTIVE;
				end else begin
					st_we      = 1'b1;
					st_waddr   = slot_q;
					st_wdata   = SLOT_SLEEP;
					cnt_d      = cnt_dec;
					pos_d      = pos_adj;
					switched_d = (cur_q == slot_q);
				end
				state_d = S_CUR_RD;
			end

			// refresh the running slot from the run list
			S_CUR_RD: begin
				lst_raddr = pos_q;
				state_d   = S_CUR_WAIT;
			end

			S_CUR_WAIT: begin
				cur_d   = lst_rdata;
				state_d = S_DONE;
			end

			// result register frees the sequencer once it is empty or its previous beat is taken
			S_DONE: begin
				if (!res_valid_q || res.ready) begin
					res_valid_d          = 1'b1;
					res_d.running_slot   = cur_ext[OUT_SLOT_W-1:0];
					res_d.switched       = switched_q;
					res_d.allocated_slot = granted_ext[OUT_SLOT_W-1:0];
					res_d.active_count   = cnt_ext[OUT_CNT_W-1:0];
					res_d.status         = stat_q;
					state_d              = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= CNT_W'(1);
			pos_q       <= '0;
			cur_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			cnt_q       <= cnt_d;
			pos_q       <= pos_d;
			cur_q       <= cur_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		slot_q     <= slot_d;
		idx_q      <= idx_d;
		fidx_q     <= fidx_d;
		found_q    <= found_d;
		switched_q <= switched_d;
		granted_q  <= granted_d;
		stat_q     <= stat_d;
		res_q      <= res_d;
	end

	assign res.valid          = res_valid_q;
	assign res.running_slot   = res_q.running_slot;
	assign res.switched       = res_q.switched;
	assign res.allocated_slot = res_q.allocated_slot;
	assign res.active_count   = res_q.active_count;
	assign res.status         = res_q.status;

endmodule
